### hw/rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the alarm schedule table.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PER_W   = 22;

    localparam logic [31:0] BIG_JUMP_RESET = 32'd60;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] SECS_PER_WEEK  = 32'd604800;

    // reciprocals for a 25-bit dividend (time >> 7): 604800 = 128 * 4725, 86400 = 128 * 675
    localparam logic [25:0] WEEK_RCP = 26'd58175219;  // ceil(2^38 / 4725)
    localparam logic [25:0] DAY_RCP  = 26'd50903317;  // ceil(2^35 / 675)

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SYNC  = 2'd3;

    localparam logic [3:0] KIND_REPEAT = 4'd0;
    localparam logic [3:0] KIND_DAILY  = 4'd1;
    localparam logic [3:0] KIND_ONCE   = 4'd2;
    localparam logic [3:0] ACTION_MAX  = 4'd2;

    typedef struct packed {
        logic [31:0] next_time;
        logic [3:0]  time_kind;
        logic [3:0]  action_kind;
        logic [15:0] period_minutes;
        logic [7:0]  weekday_mask;
    } t_entry;

    typedef struct packed {
        logic       status;
        logic       fired;
        logic [7:0] fired_index;
        logic [3:0] fired_action;
        logic       adjusted;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_RCP,
        ST_DOW,
        ST_MUL,
        ST_WB,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/ast_if.sv
// ----------------------------------------------------------------------------
// ast_req_if / ast_rsp_if
// Valid/ready channels for table commands and their results.
// ----------------------------------------------------------------------------
interface ast_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [7:0]         entry_index;
    logic [3:0]         time_kind;
    logic [3:0]         action_kind;
    logic [31:0]        first_time;
    logic [15:0]        repeat_minutes;
    logic [7:0]         day_mask;
    logic [31:0]        now;
    logic signed [32:0] time_diff;

    modport source (output valid, opcode, entry_index, time_kind, action_kind,
                    first_time, repeat_minutes, day_mask, now, time_diff,
                    input ready);
    modport sink (input valid, opcode, entry_index, time_kind, action_kind,
                  first_time, repeat_minutes, day_mask, now, time_diff,
                  output ready);
endinterface

interface ast_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic       fired;
    logic [7:0] fired_index;
    logic [3:0] fired_action;
    logic       adjusted;

    modport source (output valid, status, fired, fired_index, fired_action, adjusted,
                    input ready);
    modport sink (input valid, status, fired, fired_index, fired_action, adjusted,
                  output ready);
endinterface

### hw/rtl/alarm_schedule_table_core.sv
// ----------------------------------------------------------------------------
// alarm_schedule_table_core
// Alarm entry table: set, clear, tick (fire and reschedule) and sync.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    opcode, index, entry fields, now, time_diff
//  o_rsp     out  valid/ready    status, fired, fired_index/action, adjusted
//  i_cfg     in   write enable   big_jump_seconds
//
//  set and clear post their result straight from idle. tick and sync walk
//  all ENTRIES entries through the single-port entry memory: a read and an
//  evaluate step per entry, plus reciprocal, multiply and weekday or write
//  back for a due daily entry that is handled, plus serial divide, multiply
//  and write back for a due repeat entry sync moves; done posts the result.
//  reset empties every entry at once through per-entry valid bits.
//  a new command is taken only while idle with the result register free.
// ----------------------------------------------------------------------------
module alarm_schedule_table_core
    import ast_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    ast_req_if.sink     i_req,
    ast_rsp_if.source   o_rsp
);

    t_entry             mem [ENTRIES];
    t_entry             r_rdata;
    logic [ENTRIES-1:0] r_valid, n_valid;
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [31:0]        r_big, r_now, n_now;
    logic signed [32:0] r_diff, n_diff;
    logic [1:0]         r_op, n_op;
    logic [31:0]        r_quo, n_quo;
    logic [PER_W-1:0]   r_rem, n_rem, r_dvs, n_dvs;
    logic [4:0]         r_cnt, n_cnt;
    logic [31:0]        r_prod, n_prod;
    logic [31:0]        r_largest, n_largest;
    logic               r_fired, n_fired, r_adj, n_adj;
    logic [IDX_W-1:0]   r_fidx, n_fidx;
    logic [3:0]         r_fact, n_fact;
    t_rsp               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               req_xfer, in_ready, last;
    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic [31:0]        ent_t;
    logic               due, short_jump, skip_rep, set_ok, idx_ok;
    logic [PER_W-1:0]   per;
    logic [PER_W:0]     rem_sh;
    logic               rem_ge;
    logic [25:0]        rcp_mag;
    logic [50:0]        rcp_prod;
    logic [31:0]        rcp_q, week_rem;
    logic [2:0]         day_cnt, dow;
    logic               dow_hit;

    // decode
    always_comb begin
        idx_ok   = {1'b0, i_req.entry_index} < 9'(ENTRIES);
        set_ok   = idx_ok && (i_req.action_kind <= ACTION_MAX);
        case (i_req.time_kind)
            KIND_REPEAT: set_ok = set_ok && (i_req.repeat_minutes != 16'd0);
            KIND_DAILY:  set_ok = set_ok && (i_req.day_mask != 8'd0);
            KIND_ONCE:   set_ok = set_ok;
            default:     set_ok = 1'b0;
        endcase
        in_ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
        req_xfer = i_req.valid && in_ready;
        last     = r_idx == IDX_W'(ENTRIES - 1);
        ent_t    = r_valid[r_idx] ? r_rdata.next_time : 32'd0;
        due      = (ent_t != 32'd0) && (ent_t < r_now);
        per      = PER_W'({6'd0, r_rdata.period_minutes} * 22'd60);
        short_jump = $signed({r_diff[32], r_diff}) <= $signed({2'b00, r_big});
        skip_rep = (per == '0) ||
                   (short_jump && ($signed({13'd0, per[PER_W-1:1]}) >
                                   $signed({r_diff[32], r_diff})));
        rem_sh   = {r_rem, r_quo[31]};
        rem_ge   = rem_sh >= {1'b0, r_dvs};
        // quotient by a week (tick) or a day (sync) from time >> 7
        rcp_mag  = (r_op == OP_TICK) ? WEEK_RCP : DAY_RCP;
        rcp_prod = {26'd0, r_quo[31:7]} * {25'd0, rcp_mag};
        rcp_q    = (r_op == OP_TICK) ? {19'd0, rcp_prod[50:38]} : {16'd0, rcp_prod[50:35]};
        // weekday from the remainder mod one week
        week_rem = ent_t - r_prod;
        day_cnt  = 3'd0;
        for (int k = 1; k < 7; k++) begin
            if (week_rem >= 32'(k) * SECS_PER_DAY) begin
                day_cnt = day_cnt + 3'd1;
            end
        end
        dow     = (day_cnt >= 3'd3) ? day_cnt - 3'd3 : day_cnt + 3'd4;
        dow_hit = r_rdata.weekday_mask[7] || r_rdata.weekday_mask[dow];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_xfer && (i_req.opcode == OP_TICK || i_req.opcode == OP_SYNC)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_EVAL;
            ST_EVAL: begin
                n_state = last ? ST_DONE : ST_READ;
                if (due) begin
                    if (r_op == OP_TICK) begin
                        if (r_rdata.time_kind == KIND_DAILY) n_state = ST_RCP;
                    end else begin
                        if (r_rdata.time_kind == KIND_REPEAT && !skip_rep) begin
                            n_state = ST_DIV;
                        end else if (r_rdata.time_kind == KIND_DAILY && !short_jump) begin
                            n_state = ST_RCP;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == 5'd31) n_state = ST_MUL;
            end
            ST_RCP:  n_state = ST_MUL;
            ST_DOW:  n_state = last ? ST_DONE : ST_READ;
            ST_MUL:  n_state = (r_op == OP_TICK) ? ST_DOW : ST_WB;
            ST_WB:   n_state = last ? ST_DONE : ST_READ;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_now       = r_now;
        n_diff      = r_diff;
        n_op        = r_op;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_largest   = r_largest;
        n_fired     = r_fired;
        n_adj       = r_adj;
        n_fidx      = r_fidx;
        n_fact      = r_fact;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_rdata;
        case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_op        = i_req.opcode;
                    n_now       = i_req.now;
                    n_diff      = i_req.time_diff;
                    n_idx       = '0;
                    n_largest   = 32'd0;
                    n_fired     = 1'b0;
                    n_adj       = 1'b0;
                    n_fidx      = '0;
                    n_fact      = 4'd0;
                    n_out       = '0;
                    mem_waddr   = i_req.entry_index[IDX_W-1:0];
                    mem_wdata   = '{i_req.first_time, i_req.time_kind, i_req.action_kind,
                                    i_req.repeat_minutes, i_req.day_mask};
                    if (i_req.opcode == OP_SET) begin
                        n_out_valid   = 1'b1;
                        n_out.status  = !set_ok;
                        mem_we        = set_ok;
                        if (set_ok) n_valid[mem_waddr] = 1'b1;
                    end else if (i_req.opcode == OP_CLEAR) begin
                        n_out_valid  = 1'b1;
                        n_out.status = !idx_ok;
                        if (idx_ok) n_valid[mem_waddr] = 1'b0;
                    end
                end
            end
            ST_READ: mem_re = 1'b1;
            ST_EVAL: begin
                n_cnt = 5'd0;
                n_rem = '0;
                if (due) begin
                    if (r_op == OP_TICK) begin
                        n_quo = ent_t;
                        n_dvs = PER_W'(SECS_PER_WEEK);
                        case (r_rdata.time_kind)
                            KIND_REPEAT: mem_wdata.next_time = ent_t + {10'd0, per};
                            KIND_DAILY:  mem_wdata.next_time = ent_t;
                            default:     mem_wdata.next_time = 32'd0;
                        endcase
                        mem_we = r_rdata.time_kind != KIND_DAILY;
                        if ((r_rdata.time_kind == KIND_REPEAT ||
                             r_rdata.time_kind == KIND_ONCE) && ent_t > r_largest) begin
                            n_largest = ent_t;
                            n_fired   = 1'b1;
                            n_fidx    = r_idx;
                            n_fact    = r_rdata.action_kind;
                        end
                    end else begin
                        mem_wdata.next_time = 32'd0;
                        case (r_rdata.time_kind)
                            KIND_REPEAT: begin
                                n_quo = r_now - ent_t + {10'd0, per} - 32'd1;
                                n_dvs = per;
                            end
                            KIND_DAILY: begin
                                n_quo = r_now - ent_t + SECS_PER_DAY - 32'd1;
                                n_dvs = PER_W'(SECS_PER_DAY);
                            end
                            KIND_ONCE: mem_we = !short_jump;
                            default:   mem_we = 1'b1;
                        endcase
                    end
                end
                if (n_state == ST_READ) n_idx = r_idx + IDX_W'(1);
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle
                n_quo = {r_quo[30:0], rem_ge};
                n_rem = rem_ge ? PER_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[PER_W-1:0];
                n_cnt = r_cnt + 5'd1;
            end
            ST_RCP: n_quo = rcp_q;
            ST_DOW: begin
                mem_we              = 1'b1;
                mem_wdata.next_time = ent_t + SECS_PER_DAY;
                if (dow_hit && ent_t > r_largest) begin
                    n_largest = ent_t;
                    n_fired   = 1'b1;
                    n_fidx    = r_idx;
                    n_fact    = r_rdata.action_kind;
                end
                if (!last) n_idx = r_idx + IDX_W'(1);
            end
            ST_MUL: n_prod = 32'(r_quo * {10'd0, r_dvs});
            ST_WB: begin
                mem_we              = 1'b1;
                mem_wdata.next_time = ent_t + r_prod;
                if (r_quo != 32'd0) n_adj = 1'b1;
                if (!last) n_idx = r_idx + IDX_W'(1);
            end
            ST_DONE: begin
                n_out_valid        = 1'b1;
                n_out.status       = 1'b0;
                n_out.fired        = r_fired;
                n_out.fired_index  = 8'(r_fidx);
                n_out.fired_action = r_fact;
                n_out.adjusted     = (r_op == OP_SYNC) && r_adj;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_big       <= BIG_JUMP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_big <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_now     <= n_now;
        r_diff    <= n_diff;
        r_op      <= n_op;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_cnt     <= n_cnt;
        r_prod    <= n_prod;
        r_largest <= n_largest;
        r_fired   <= n_fired;
        r_adj     <= n_adj;
        r_fidx    <= n_fidx;
        r_fact    <= n_fact;
        r_out     <= n_out;
    end

    assign i_req.ready        = in_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.fired        = r_out.fired;
    assign o_rsp.fired_index  = r_out.fired_index;
    assign o_rsp.fired_action = r_out.fired_action;
    assign o_rsp.adjusted     = r_out.adjusted;

endmodule

### hw/rtl/ast_checker.sv
// ----------------------------------------------------------------------------
// ast_checker
// Port-level checks of the alarm schedule table.
// ----------------------------------------------------------------------------
module ast_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_status,
    input logic       i_fired,
    input logic [7:0] i_fired_index,
    input logic [3:0] i_fired_action,
    input logic       i_adjusted
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // a command either posts at once or holds off the next one
    a_busy_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> (i_rsp_valid || !i_req_ready))
        else $error("command taken without result or busy");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_no_fire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_fired) |-> (i_fired_index == 8'd0 && i_fired_action == 4'd0))
        else $error("fire fields set without fire");

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_adjusted) |-> (!i_fired && !i_status))
        else $error("adjusted mixed with other result kinds");

endmodule

bind alarm_schedule_table_core ast_checker u_ast_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_fired        (o_rsp.fired),
    .i_fired_index  (o_rsp.fired_index),
    .i_fired_action (o_rsp.fired_action),
    .i_adjusted     (o_rsp.adjusted)
);
